### hdl/sfr_pkg.sv
// Shared types and constants of the stuffed frame receiver.
// Depends on nothing; the top level, the core and the simulation files import it.
package sfr_pkg;

    localparam logic [7:0] CODE_START = 8'hEA;
    localparam logic [7:0] CODE_END   = 8'hEB;
    localparam logic [7:0] CODE_ESC   = 8'hEC;
    localparam logic [7:0] ESC_MASK   = 8'hAB;
    localparam logic [7:0] XOR_SEED   = 8'hAB;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_BYTE = 2'd1;
    localparam logic [1:0] KIND_GOOD = 2'd2;
    localparam logic [1:0] KIND_BAD  = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic [8:0] frame_length;
    } sfr_result_t;

endpackage

### hdl/sfr_in_if.sv
// Input channel of the stuffed frame receiver: one raw line byte per transfer.
// Depends on nothing.
interface sfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

### hdl/sfr_out_if.sv
// Result channel of the stuffed frame receiver: one result item per transfer.
// Depends on nothing.
interface sfr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [8:0] frame_length;

    modport source (output valid, output kind, output data_byte, output byte_index,
                    output frame_length, input ready);
    modport sink   (input valid, input kind, input data_byte, input byte_index,
                    input frame_length, output ready);
endinterface

### hdl/stuffed_frame_receiver_top.sv
// Top level of the stuffed frame receiver: input register, deframing core and
// result register. Depends on sfr_pkg, sfr_in_if, sfr_out_if and sfr_core.
//
// Usage: line carries one raw received byte per transfer, start, end and escape
// codes included. Every accepted byte gives exactly one transfer on result:
// kind 0 for a code or a dropped byte, kind 1 with the unescaped byte and its
// index for a stored frame byte, and kind 2 or 3 with the verdict at an end code.
// Each accepted byte passes the input register, then the core's combinational
// update feeds the result register, whose valid flag drives result.valid.
// Throughput is one byte per cycle while result is not stalled; the bound is
// the core's state update, which takes one byte per clock.
// While result is stalled, both registers hold and line.ready drops once the
// input register is full too; no byte is lost or repeated.
// Reset clears both valid flags and returns the core to the state of an empty
// frame with the XOR check seeded.
module stuffed_frame_receiver_top
    import sfr_pkg::*;
#(
    parameter int FRAME_CAPACITY = 256
)
(
    input  logic clk,
    input  logic rst_n,
    sfr_in_if.sink    line,
    sfr_out_if.source result
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    sfr_result_t out_reg;
    sfr_result_t core_result;
    logic        out_advance;
    logic        step;

    assign out_advance = !out_valid_reg || result.ready;
    assign step        = in_valid_reg && out_advance;
    assign line.ready  = !in_valid_reg || out_advance;

    sfr_core #(
        .FRAME_CAPACITY (FRAME_CAPACITY)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .line_byte (in_byte_reg),
        .result    (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (line.ready)
            begin
                in_valid_reg <= line.valid;
            end
            if (out_advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (line.valid && line.ready)
        begin
            in_byte_reg <= line.in_byte;
        end
        if (step)
        begin
            out_reg <= core_result;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.kind         = out_reg.kind;
    assign result.data_byte    = out_reg.data_byte;
    assign result.byte_index   = out_reg.byte_index;
    assign result.frame_length = out_reg.frame_length;

endmodule

### hdl/sfr_core.sv
// Deframing state and running checks of the stuffed frame receiver.
// Depends on sfr_pkg; the state advances by one byte when step is high.
module sfr_core
    import sfr_pkg::*;
#(
    parameter int FRAME_CAPACITY = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  line_byte,
    output sfr_result_t result
);

    logic [8:0] write_index_reg,    write_index_next;
    logic       escape_pending_reg, escape_pending_next;
    logic [7:0] payload_length_reg, payload_length_next;
    logic [7:0] xor_acc_reg,        xor_acc_next;
    logic [7:0] sum_acc_reg,        sum_acc_next;
    logic [7:0] xor_check_reg,      xor_check_next;
    logic [7:0] sum_check_reg,      sum_check_next;

    logic [7:0] unescaped;
    logic [8:0] len_ext;
    logic [9:0] min_count;
    logic       good;

    assign unescaped = escape_pending_reg ? (line_byte ^ ESC_MASK) : line_byte;
    assign len_ext   = {1'b0, payload_length_reg};
    assign min_count = {2'b00, payload_length_reg} + 10'd3;
    assign good      = ({1'b0, write_index_reg} >= min_count)
                     && (xor_acc_reg == xor_check_reg)
                     && (sum_acc_reg == sum_check_reg);

    always_comb
    begin
        write_index_next    = write_index_reg;
        escape_pending_next = escape_pending_reg;
        payload_length_next = payload_length_reg;
        xor_acc_next        = xor_acc_reg;
        sum_acc_next        = sum_acc_reg;
        xor_check_next      = xor_check_reg;
        sum_check_next      = sum_check_reg;
        result              = '0;
        result.kind         = KIND_NONE;

        if (line_byte == CODE_START)
        begin
            write_index_next    = '0;
            escape_pending_next = 1'b0;
            payload_length_next = '0;
            xor_acc_next        = XOR_SEED;
            sum_acc_next        = '0;
            xor_check_next      = '0;
            sum_check_next      = '0;
        end
        else if (line_byte == CODE_ESC)
        begin
            escape_pending_next = 1'b1;
        end
        else if (line_byte == CODE_END)
        begin
            escape_pending_next = 1'b0;
            if (good)
            begin
                result.kind         = KIND_GOOD;
                result.frame_length = write_index_reg;
            end
            else
            begin
                result.kind = KIND_BAD;
            end
        end
        else if (write_index_reg < 9'(FRAME_CAPACITY))
        begin
            // Bytes past the capacity are dropped and leave the escape flag as it was.
            escape_pending_next = 1'b0;
            if (write_index_reg == 9'd0)
            begin
                payload_length_next = unescaped;
            end
            else if (write_index_reg <= len_ext)
            begin
                xor_acc_next = xor_acc_reg ^ unescaped;
                sum_acc_next = sum_acc_reg + unescaped;
            end
            else if (write_index_reg == len_ext + 9'd1)
            begin
                xor_check_next = unescaped;
            end
            else if (write_index_reg == len_ext + 9'd2)
            begin
                sum_check_next = unescaped;
            end
            write_index_next  = write_index_reg + 9'd1;
            result.kind       = KIND_BYTE;
            result.data_byte  = unescaped;
            result.byte_index = write_index_reg[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_index_reg    <= '0;
            escape_pending_reg <= 1'b0;
            payload_length_reg <= '0;
            xor_acc_reg        <= XOR_SEED;
            sum_acc_reg        <= '0;
            xor_check_reg      <= '0;
            sum_check_reg      <= '0;
        end
        else if (step)
        begin
            write_index_reg    <= write_index_next;
            escape_pending_reg <= escape_pending_next;
            payload_length_reg <= payload_length_next;
            xor_acc_reg        <= xor_acc_next;
            sum_acc_reg        <= sum_acc_next;
            xor_check_reg      <= xor_check_next;
            sum_check_reg      <= sum_check_next;
        end
    end

endmodule

### sim/sfr_result_checker.sv
// Result checker of the stuffed frame receiver: watches both channels, predicts
// every result from the accepted line bytes and compares it field by field.
// Depends on sfr_pkg, sfr_in_if and sfr_out_if.
module sfr_result_checker
    import sfr_pkg::*;
#(
    parameter int FRAME_CAPACITY = 256
)
(
    input  logic clk,
    input  logic rst_n,
    sfr_in_if    line,
    sfr_out_if   result,
    output int   fail_count,
    output int   pending
);

    localparam int PRINT_CAP = 40;

    sfr_result_t expected_results[$];

    logic [8:0] wr_idx;
    logic       esc_armed;
    logic [7:0] frame_len;
    logic [7:0] xor_run;
    logic [7:0] sum_run;
    logic [7:0] xor_chk;
    logic [7:0] sum_chk;

    task automatic report(input string what, input int got, input int want);
        if (fail_count < PRINT_CAP)
        begin
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        end
        fail_count++;
    endtask

    task automatic clear_frame();
        wr_idx    = '0;
        esc_armed = 1'b0;
        frame_len = '0;
        xor_run   = XOR_SEED;
        sum_run   = '0;
        xor_chk   = '0;
        sum_chk   = '0;
    endtask

    // Advances the deframer state by one line byte and queues the result it causes.
    task automatic predict_byte(input logic [7:0] b);
        sfr_result_t r;
        logic [7:0]  d;
        r      = '0;
        r.kind = KIND_NONE;
        if (b == CODE_START)
        begin
            clear_frame();
        end
        else if (b == CODE_ESC)
        begin
            esc_armed = 1'b1;
        end
        else if (b != CODE_END)
        begin
            // A byte arriving at a full frame is dropped and leaves the escape flag alone.
            if (int'(wr_idx) < FRAME_CAPACITY)
            begin
                d         = esc_armed ? (b ^ ESC_MASK) : b;
                esc_armed = 1'b0;
                if (wr_idx == 9'd0)
                    frame_len = d;
                else if (wr_idx <= {1'b0, frame_len})
                begin
                    xor_run = xor_run ^ d;
                    sum_run = sum_run + d;
                end
                else if (wr_idx == {1'b0, frame_len} + 9'd1)
                    xor_chk = d;
                else if (wr_idx == {1'b0, frame_len} + 9'd2)
                    sum_chk = d;
                r.kind       = KIND_BYTE;
                r.data_byte  = d;
                r.byte_index = wr_idx[7:0];
                wr_idx       = wr_idx + 9'd1;
            end
        end
        else
        begin
            esc_armed = 1'b0;
            if (({1'b0, wr_idx} >= {2'b00, frame_len} + 10'd3) &&
                (xor_run == xor_chk) && (sum_run == sum_chk))
            begin
                r.kind         = KIND_GOOD;
                r.frame_length = wr_idx;
            end
            else
            begin
                r.kind = KIND_BAD;
            end
        end
        expected_results.push_back(r);
    endtask

    task automatic check_result();
        sfr_result_t want;
        if (expected_results.size() == 0)
        begin
            report("result with nothing expected, kind", int'(result.kind), -1);
        end
        else
        begin
            want = expected_results.pop_front();
            if (result.kind !== want.kind)
                report("kind", int'(result.kind), int'(want.kind));
            if (result.data_byte !== want.data_byte)
                report("data_byte", int'(result.data_byte), int'(want.data_byte));
            if (result.byte_index !== want.byte_index)
                report("byte_index", int'(result.byte_index), int'(want.byte_index));
            if (result.frame_length !== want.frame_length)
                report("frame_length", int'(result.frame_length), int'(want.frame_length));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_frame();
            expected_results.delete();
            pending <= 0;
        end
        else
        begin
            // The result of an earlier byte is popped before this cycle's byte is queued.
            if (result.valid && result.ready)
                check_result();
            if (line.valid && line.ready)
                predict_byte(line.in_byte);
            pending <= expected_results.size();
        end
    end

endmodule

### sim/stuffed_frame_receiver_top_test.sv
// Testbench top of the stuffed frame receiver: clock, reset, line byte stimulus,
// result back-pressure, watchdog and verdict.
// Depends on sfr_pkg, sfr_in_if, sfr_out_if, sfr_result_checker and the block's top.
module stuffed_frame_receiver_top_test;
    import sfr_pkg::*;

    localparam int CAPACITY     = 256;
    localparam int RANDOM_ITEMS = 700;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 250;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 8;

    typedef enum int {
        FRAME_GOOD,
        FRAME_LONG,
        FRAME_BAD_XOR,
        FRAME_BAD_SUM,
        FRAME_SHORT
    } frame_mode_t;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;

    logic [7:0] line_bytes[$];

    sfr_in_if  line_ch();
    sfr_out_if result_ch();

    stuffed_frame_receiver_top #(
        .FRAME_CAPACITY(CAPACITY)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .line   (line_ch),
        .result (result_ch)
    );

    sfr_result_checker #(
        .FRAME_CAPACITY(CAPACITY)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .line       (line_ch),
        .result     (result_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    function automatic bit is_code(input logic [7:0] b);
        return (b == CODE_START) || (b == CODE_END) || (b == CODE_ESC);
    endfunction

    task automatic push_raw(input logic [7:0] b);
        line_bytes.push_back(b);
    endtask

    // Sends a frame byte, escaped when it collides with a code and now and then
    // without need, sometimes with a doubled escape.
    task automatic push_data(input logic [7:0] d);
        if (is_code(d) || (!is_code(d ^ ESC_MASK) && $urandom_range(0, 7) == 0))
        begin
            if ($urandom_range(0, 15) == 0)
                push_raw(CODE_ESC);
            push_raw(CODE_ESC);
            push_raw(d ^ ESC_MASK);
        end
        else
        begin
            push_raw(d);
        end
    endtask

    task automatic build_frame(input int len, input frame_mode_t mode, input bit with_start);
        logic [7:0] body[$];
        logic [7:0] x;
        logic [7:0] s;
        logic [7:0] d;
        x = XOR_SEED;
        s = 8'h00;
        body.push_back(8'(len));
        for (int i = 0; i < len; i++)
        begin
            d = 8'($urandom_range(0, 255));
            body.push_back(d);
            x = x ^ d;
            s = s + d;
        end
        if (mode == FRAME_BAD_XOR)
            x = x ^ (8'h01 << $urandom_range(0, 7));
        if (mode == FRAME_BAD_SUM)
            s = s + 8'($urandom_range(1, 255));
        body.push_back(x);
        body.push_back(s);
        if (mode == FRAME_LONG)
            repeat ($urandom_range(1, 4)) body.push_back(8'($urandom_range(0, 255)));
        if (mode == FRAME_SHORT)
            repeat ($urandom_range(1, body.size())) void'(body.pop_back());
        if (with_start)
            push_raw(CODE_START);
        foreach (body[i])
            push_data(body[i]);
        push_raw(CODE_END);
    endtask

    task automatic build_directed();
        push_raw(CODE_END);
        push_raw(CODE_ESC);
        push_raw(CODE_START);
        // Empty payload: the checks are the seed and zero.
        push_raw(8'h00);
        push_raw(XOR_SEED);
        push_raw(8'h00);
        push_raw(CODE_END);
        // Appends after the end code and gives a fresh verdict.
        push_raw(8'hFF);
        push_raw(CODE_END);
        // One escaped payload byte behind a doubled escape, then an escape cleared by the end.
        push_raw(CODE_START);
        push_raw(8'h01);
        push_raw(CODE_ESC);
        push_raw(CODE_ESC);
        push_raw(CODE_START ^ ESC_MASK);
        push_raw(XOR_SEED ^ CODE_START);
        push_raw(CODE_ESC);
        push_raw(CODE_START ^ ESC_MASK);
        push_raw(CODE_ESC);
        push_raw(CODE_END);
        push_raw(8'h00);
        push_raw(CODE_START);
        push_raw(8'h02);
        push_raw(8'hFF);
        push_raw(CODE_END);
    endtask

    // Fills a frame to capacity exactly and then offers bytes that must be dropped.
    task automatic build_full_frame();
        logic [7:0] x;
        logic [7:0] s;
        logic [7:0] d;
        x = XOR_SEED;
        s = 8'h00;
        push_raw(CODE_START);
        push_data(8'(CAPACITY - 3));
        for (int i = 0; i < CAPACITY - 3; i++)
        begin
            d = 8'($urandom_range(0, 255));
            push_data(d);
            x = x ^ d;
            s = s + d;
        end
        push_data(x);
        push_data(s);
        push_data(8'($urandom_range(0, 255)));
        push_raw(CODE_ESC);
        push_data(8'($urandom_range(0, 255)));
        push_raw(CODE_END);
    endtask

    task automatic build_random();
        int          first;
        int          pick;
        int          len;
        frame_mode_t mode;
        first = line_bytes.size();
        build_full_frame();
        while (line_bytes.size() < first + RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
            if (pick < 90)
            begin
                if (pick < 62)
                    mode = FRAME_GOOD;
                else if (pick < 70)
                    mode = FRAME_LONG;
                else if (pick < 76)
                    mode = FRAME_BAD_XOR;
                else if (pick < 82)
                    mode = FRAME_BAD_SUM;
                else
                    mode = FRAME_SHORT;
                build_frame(len, mode, $urandom_range(0, 19) != 0);
            end
            else if (pick < 96)
            begin
                repeat ($urandom_range(1, 6)) push_raw(8'($urandom_range(0, 255)));
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: push_raw(CODE_START);
                    1: push_raw(CODE_END);
                    default: push_raw(CODE_ESC);
                endcase
            end
        end
    endtask

    initial
    begin : line_driver
        int burst_left;
        int gap;
        int idx;
        rst_n           <= 1'b0;
        line_ch.valid   <= 1'b0;
        line_ch.in_byte <= 8'h00;
        build_directed();
        build_random();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        burst_left = 0;
        idx        = 0;
        while (idx < line_bytes.size())
        begin
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    burst_left = $urandom_range(60, 120);
                    gap        = 0;
                end
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                if (gap > 0)
                begin
                    line_ch.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            line_ch.valid   <= 1'b1;
            line_ch.in_byte <= line_bytes[idx];
            @(posedge clk);
            while (!line_ch.ready)
                @(posedge clk);
            idx++;
            burst_left--;
        end
        line_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("stuffed_frame_receiver_top_test: done, clean");
        else
            $display("stuffed_frame_receiver_top_test: done, errors");
        $finish;
    end

    // Back-pressure switches at random among four patterns; one long hold-off lets
    // the block fill up while the line keeps offering bytes.
    initial
    begin : result_sink
        int cyc;
        int mode;
        cyc  = 0;
        mode = 0;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc == HOLD_AT)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (cyc % 64 == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0: result_ch.ready <= 1'b1;
                1: result_ch.ready <= 1'($urandom_range(0, 1));
                2: result_ch.ready <= ($urandom_range(0, 3) == 0);
                default: result_ch.ready <= (cyc % 8 != 5);
            endcase
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        @(posedge rst_n);
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((line_ch.valid && line_ch.ready) || (result_ch.valid && result_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("stuffed_frame_receiver_top_test: done, errors");
        $finish;
    end

endmodule
